[src/spq_pkg.sv]
// spq_pkg: shared types and constants for the stable priority queue.
// Holds the entry type, opcode and status codes, and the cell control group.
// No dependencies.
package spq_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned PRIO_W  = 16;
    localparam int unsigned OCC_W   = 5;

    // Operation carried by an input transaction
    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } t_opcode;

    // Completion code of a transaction
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
    } t_entry;

    // Per-cycle control that every cell sees
    typedef struct packed {
        logic enq;       // accepted enqueue that fits
        logic deq;       // accepted dequeue of a stored entry
        logic occupied;  // this cell holds a live entry
    } t_cell_ctrl;

endpackage

[src/spq_cell.sv]
// spq_cell: one slot of the sorted shift-register queue.
// Compares its entry with the incoming one and picks hold, load, or shift.
// Depends on spq_pkg.
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  spq_pkg::t_entry     i_new,
    input  spq_pkg::t_entry     i_prev,
    input  logic                i_prev_keep,
    input  spq_pkg::t_entry     i_next,
    output spq_pkg::t_entry     o_entry,
    output logic                o_keep
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Entry stays put on enqueue when it is live and not behind the new one
    assign o_keep = i_ctrl.occupied &&
                    ($signed(r_entry.prio) <= $signed(i_new.prio));

    // Next entry: hold, take the new entry, shift up from prev, or shift down
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_prev_keep) begin
                n_entry = i_new;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[src/stable_priority_queue_unit.sv]
// stable_priority_queue_unit: top level of the sorted priority queue.
// Instantiates a row of spq_cell slots; depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per
//   transaction: enqueue of a value and priority, or dequeue of the head.
//   Entries are kept sorted by ascending signed priority; equal priorities
//   stay in arrival order. Each input transaction yields exactly one
//   result transaction on the output channel (o_res_valid / i_res_ready)
//   with the dequeued entry (zero on enqueue), a status code, and the
//   occupancy after the operation.
//   The result is registered and appears in the cycle after the input is accepted.
//   Throughput: one operation per cycle while results are taken; every cell compares against the
//   incoming priority in parallel and shifts in the same cycle.
//   An enqueue into a full queue is dropped with status FULL; a dequeue of
//   an empty queue returns status EMPTY and leaves the queue unchanged.
//   Reset clears the entry count and the output valid; no clearing pass.
//   When the receiver stalls, the result register holds and o_in_ready
//   drops until the result is taken.
module stable_priority_queue_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0]     i_item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]      i_item_priority,
    output logic                                   o_res_valid,
    input  logic                                   i_res_ready,
    output logic signed [spq_pkg::VALUE_W-1:0]     o_out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]      o_out_priority,
    output logic                                   o_out_valid,
    output logic [1:0]                             o_status,
    output logic [spq_pkg::OCC_W-1:0]              o_occupancy,
    output logic                                   o_is_empty
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_res_valid;
    logic                    n_res_valid;
    spq_pkg::t_entry         r_res_entry;
    spq_pkg::t_entry         n_res_entry;
    logic                    r_res_delivered;
    logic                    n_res_delivered;
    spq_pkg::t_status        r_status;
    spq_pkg::t_status        n_status;
    logic [CW-1:0]           r_res_count;

    logic                    fire;
    logic                    is_full;
    logic                    is_none;
    logic                    enq_ok;
    logic                    deq_ok;
    spq_pkg::t_opcode        opcode;
    spq_pkg::t_entry         new_entry;
    spq_pkg::t_entry         cell_entry [DEPTH];
    logic [DEPTH-1:0]        cell_keep;

    // Input handshake: take a transaction when the result slot frees up
    assign o_in_ready = !r_res_valid || i_res_ready;
    assign fire       = i_in_valid && o_in_ready;
    assign opcode     = spq_pkg::t_opcode'(i_opcode);
    assign new_entry  = '{value: i_item_value, prio: i_item_priority};

    assign is_full = (r_count == CW'(DEPTH));
    assign is_none = (r_count == '0);
    assign enq_ok  = fire && (opcode == spq_pkg::OP_ENQUEUE) && !is_full;
    assign deq_ok  = fire && (opcode == spq_pkg::OP_DEQUEUE) && !is_none;

    // Row of cells, head at index 0
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_pkg::t_cell_ctrl ctrl;
        spq_pkg::t_entry     prev_entry;
        spq_pkg::t_entry     next_entry;
        logic                prev_keep;

        assign ctrl.enq      = enq_ok;
        assign ctrl.deq      = deq_ok;
        assign ctrl.occupied = (r_count > CW'(g));

        if (g == 0) begin : g_head
            assign prev_entry = new_entry;
            assign prev_keep  = 1'b1;
        end else begin : g_body
            assign prev_entry = cell_entry[g-1];
            assign prev_keep  = cell_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_entry = cell_entry[g];
        end else begin : g_mid
            assign next_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_new       (new_entry),
            .i_prev      (prev_entry),
            .i_prev_keep (prev_keep),
            .i_next      (next_entry),
            .o_entry     (cell_entry[g]),
            .o_keep      (cell_keep[g])
        );
    end

    // Next count, result payload and status
    always_comb begin
        n_count         = r_count;
        n_res_valid     = r_res_valid;
        n_res_entry     = r_res_entry;
        n_res_delivered = r_res_delivered;
        n_status        = r_status;
        if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
        if (fire) begin
            n_res_valid     = 1'b1;
            n_res_entry     = '0;
            n_res_delivered = 1'b0;
            n_status        = spq_pkg::ST_DONE;
            if (enq_ok) begin
                n_count = r_count + CW'(1);
            end else if (deq_ok) begin
                n_count         = r_count - CW'(1);
                n_res_entry     = cell_entry[0];
                n_res_delivered = 1'b1;
            end else if (opcode == spq_pkg::OP_ENQUEUE) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_status = spq_pkg::ST_EMPTY;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_res_entry     <= n_res_entry;
        r_res_delivered <= n_res_delivered;
        r_status        <= n_status;
    end

    // Result count register: occupancy after the transaction
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res_count <= n_count;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_out_value    = r_res_entry.value;
    assign o_out_priority = r_res_entry.prio;
    assign o_out_valid    = r_res_delivered;
    assign o_status       = r_status;
    assign o_is_empty     = (r_res_count == '0);

    // Occupancy is reported in its low bits, zero-extended when the count is narrower
    if (CW >= spq_pkg::OCC_W) begin : g_occ_trunc
        assign o_occupancy = r_res_count[spq_pkg::OCC_W-1:0];
    end else begin : g_occ_ext
        assign o_occupancy = {{(spq_pkg::OCC_W - CW){1'b0}}, r_res_count};
    end

endmodule

[tb/sv/testbench.sv]
// testbench: self-checking bench for stable_priority_queue_unit.
// Tracks the expected queue contents in a scoreboard class and checks every
// result transaction against it; depends on spq_pkg and the unit under test.
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_TICKS = 4;
    localparam int unsigned PHASE_ITEMS  = 213;

    // One expected result transaction
    typedef struct {
        logic signed [spq_pkg::VALUE_W-1:0] value;
        logic signed [spq_pkg::PRIO_W-1:0]  prio;
        logic                               delivered;
        spq_pkg::t_status                   status;
        logic [spq_pkg::OCC_W-1:0]          occupancy;
        logic                               is_empty;
    } t_spq_outcome;

    // Mirror of the queue contents plus the results still owed by the unit
    class spq_scoreboard;
        logic signed [spq_pkg::VALUE_W-1:0] held_values[$];
        logic signed [spq_pkg::PRIO_W-1:0]  held_prios[$];
        t_spq_outcome                       expected_q[$];
        int unsigned                        errors;
        int unsigned                        checked;
        int unsigned                        delivered;
        int unsigned                        full_drops;
        int unsigned                        empty_drops;
        int unsigned                        peak_fill;

        // Apply an accepted operation to the mirror and queue its outcome
        function void note_op(spq_pkg::t_opcode op,
                              logic signed [spq_pkg::VALUE_W-1:0] value,
                              logic signed [spq_pkg::PRIO_W-1:0] prio);
            t_spq_outcome o;
            int unsigned  pos;
            o.value     = '0;
            o.prio      = '0;
            o.delivered = 1'b0;
            o.status    = spq_pkg::ST_DONE;
            if (op == spq_pkg::OP_ENQUEUE) begin
                if (held_values.size() >= QUEUE_DEPTH) begin
                    o.status = spq_pkg::ST_FULL;
                    full_drops++;
                end else begin
                    // stable insert: goes behind every entry of equal or lower number
                    pos = 0;
                    while (pos < held_prios.size() && held_prios[pos] <= prio)
                        pos++;
                    held_values.insert(pos, value);
                    held_prios.insert(pos, prio);
                end
            end else begin
                if (held_values.size() == 0) begin
                    o.status = spq_pkg::ST_EMPTY;
                    empty_drops++;
                end else begin
                    o.value     = held_values.pop_front();
                    o.prio      = held_prios.pop_front();
                    o.delivered = 1'b1;
                    delivered++;
                end
            end
            o.occupancy = spq_pkg::OCC_W'(held_values.size());
            o.is_empty  = (held_values.size() == 0);
            if (held_values.size() > peak_fill)
                peak_fill = held_values.size();
            expected_q.push_back(o);
        endfunction

        function void field_check(string name, logic [spq_pkg::VALUE_W-1:0] exp_v,
                                  logic [spq_pkg::VALUE_W-1:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(logic signed [spq_pkg::VALUE_W-1:0] value,
                                   logic signed [spq_pkg::PRIO_W-1:0] prio,
                                   logic valid, logic [1:0] status,
                                   logic [spq_pkg::OCC_W-1:0] occupancy,
                                   logic is_empty);
            t_spq_outcome e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing outstanding, value %h status %h",
                         $time, value, status);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            field_check("out_value", e.value, value);
            field_check("out_priority", e.prio, prio);
            field_check("out_valid", e.delivered, valid);
            field_check("status", e.status, status);
            field_check("occupancy", e.occupancy, occupancy);
            field_check("is_empty", e.is_empty, is_empty);
        endfunction
    endclass

    logic                               i_clk           = 1'b0;
    logic                               i_rst_n         = 1'b0;
    logic                               i_in_valid      = 1'b0;
    logic                               i_opcode        = 1'b0;
    logic signed [spq_pkg::VALUE_W-1:0] i_item_value    = '0;
    logic signed [spq_pkg::PRIO_W-1:0]  i_item_priority = '0;
    logic                               i_res_ready     = 1'b0;
    logic                               o_in_ready;
    logic                               o_res_valid;
    logic signed [spq_pkg::VALUE_W-1:0] o_out_value;
    logic signed [spq_pkg::PRIO_W-1:0]  o_out_priority;
    logic                               o_out_valid;
    logic [1:0]                         o_status;
    logic [spq_pkg::OCC_W-1:0]          o_occupancy;
    logic                               o_is_empty;

    int unsigned   send_idle_pct = 0;
    int unsigned   stall_pct     = 0;
    int unsigned   cycle_count   = 0;
    spq_scoreboard sb;

    stable_priority_queue_unit #(
        .DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_occupancy     (o_occupancy),
        .o_is_empty      (o_is_empty)
    );

    always #2 i_clk = ~i_clk;

    // Result side: check accepted results, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready)
            sb.check_result(o_out_value, o_out_priority, o_out_valid, o_status,
                            o_occupancy, o_is_empty);
        i_res_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Present one operation, with optional idle cycles first, until accepted
    task automatic send_op(spq_pkg::t_opcode op,
                           logic signed [spq_pkg::VALUE_W-1:0] value,
                           logic signed [spq_pkg::PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_item_value    <= value;
        i_item_priority <= prio;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_op(op, value, prio);
    endtask

    // Random mix; the enqueue share swings so the queue fills and drains
    task automatic run_random_phase(int unsigned n_items);
        int unsigned                       k;
        int unsigned                       enq_pct;
        int unsigned                       sel;
        spq_pkg::t_opcode                  op;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        enq_pct = 50;
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
            end
            op  = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQUEUE
                                                 : spq_pkg::OP_DEQUEUE;
            sel = $urandom_range(99);
            // narrow band gives plenty of ties
            if (sel < 60)
                prio = spq_pkg::PRIO_W'(int'($urandom_range(6)) - 3);
            else if (sel < 85)
                prio = spq_pkg::PRIO_W'($urandom);
            else if (sel < 92)
                prio = 16'h7FFF;
            else
                prio = 16'h8000;
            send_op(op, spq_pkg::VALUE_W'($urandom), prio);
        end
    endtask

    initial begin
        int unsigned k;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, field extremes, last-entry removal
        send_op(spq_pkg::OP_DEQUEUE, 32'h5A5A_A5A5, 16'h1234);
        send_op(spq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF);
        send_op(spq_pkg::OP_ENQUEUE, 32'h8000_0000, 16'h8000);
        send_op(spq_pkg::OP_ENQUEUE, 32'h0000_0000, 16'h0000);
        send_op(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
        for (k = 0; k < 4; k++)
            send_op(spq_pkg::OP_DEQUEUE, '0, '0);
        send_op(spq_pkg::OP_DEQUEUE, '1, '1);

        // Fill with two tied priority bands, then push one more while full
        for (k = 0; k < QUEUE_DEPTH; k++)
            send_op(spq_pkg::OP_ENQUEUE, spq_pkg::VALUE_W'(k + 100),
                    k[0] ? 16'sd5 : -16'sd5);
        send_op(spq_pkg::OP_ENQUEUE, 32'hDEAD_BEEF, 16'h8000);

        // Random phases with different idle and stall patterns
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 67;
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        stall_pct     = 67;
        run_random_phase(PHASE_ITEMS);
        send_idle_pct = 16;
        stall_pct     = 16;
        run_random_phase(PHASE_ITEMS);
        i_in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Checked %0d transactions: %0d entries served, %0d full drops,",
                 sb.checked, sb.delivered, sb.full_drops);
        $display("%0d empty dequeues, peak fill %0d of %0d, %0d errors.",
                 sb.empty_drops, sb.peak_fill, QUEUE_DEPTH, sb.errors);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[stable_priority_queue_unit.f]
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue_unit.sv
tb/sv/testbench.sv
